[src/pca_pkg.sv]
// ----------------------------------------------------------------------------
// pca_pkg
// Shared widths, register indexes, reset values and control types for the
// pressure calibration and averaging core.
// ----------------------------------------------------------------------------
package pca_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int PRESS_W    = 7;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int MEAS_W     = 16;

    // divisor magnitude, partial remainder and dividend/quotient widths
    localparam int DEN_W      = 10;
    localparam int REM_W      = DEN_W + 1;
    localparam int DIV_W      = 22;
    localparam int DIV_RADIX  = 2;
    localparam int DIV_STEPS  = DIV_W / DIV_RADIX;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam int WINDOW_LEN_DEF = 4;
    localparam int TENTHS         = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_OFFSET   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_PRESSURE = 2'd2;

    localparam logic [SAMPLE_W-1:0] ZERO_OFFSET_RST   = 10'd0;
    localparam logic [SAMPLE_W-1:0] SPAN_OFFSET_RST   = 10'd1023;
    localparam logic [PRESS_W-1:0]  SPAN_PRESSURE_RST = 7'd40;

    localparam logic signed [MEAS_W-1:0] MEAS_MAX = 16'sh7FFF;
    localparam logic signed [MEAS_W-1:0] MEAS_MIN = 16'sh8000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_CAL,
        ST_SAT,
        ST_RING,
        ST_MEAN_LOAD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic mul;
        logic div_step;
        logic sat;
        logic ring_upd;
        logic mean_load;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

endpackage

[src/pca_in_if.sv]
// ----------------------------------------------------------------------------
// pca_in_if
// Request channel carrying one raw converter code.
// ----------------------------------------------------------------------------
interface pca_in_if
    import pca_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

[src/pca_out_if.sv]
// ----------------------------------------------------------------------------
// pca_out_if
// Result channel carrying calibrated and filtered pressure.
// ----------------------------------------------------------------------------
interface pca_out_if
    import pca_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [MEAS_W-1:0] measured_pressure;
    logic signed [MEAS_W-1:0] filtered_pressure;
    logic [SAMPLE_W-1:0]      raw_echo;
    logic                     span_error;

    modport source (output valid, output measured_pressure, output filtered_pressure,
                    output raw_echo, output span_error, input ready);
    modport sink   (input valid, input measured_pressure, input filtered_pressure,
                    input raw_echo, input span_error, output ready);
endinterface

[src/pca_ctrl.sv]
// ----------------------------------------------------------------------------
// pca_ctrl
// Sequencer: multiply, calibration divide, saturate, ring update, mean,
// result hand-over.
// ----------------------------------------------------------------------------
module pca_ctrl
    import pca_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              last_step;

    assign last_step = (step_reg == STEP_W'(DIV_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                step_next  = '0;
                state_next = ST_DIV_CAL;
            end
            ST_DIV_CAL:
            begin
                step_next = step_reg + 1'b1;
                if (last_step)
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:       state_next = ST_RING;
            ST_RING:      state_next = ST_MEAN_LOAD;
            ST_MEAN_LOAD: state_next = ST_OUT;
            ST_OUT:
            begin
                // hold until the output register is free
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_MUL:       cmd.mul       = 1'b1;
            ST_DIV_CAL:   cmd.div_step  = 1'b1;
            ST_SAT:       cmd.sat       = 1'b1;
            ST_RING:      cmd.ring_upd  = 1'b1;
            ST_MEAN_LOAD: cmd.mean_load = 1'b1;
            ST_OUT:       cmd.out_load  = !status.out_busy;
            default:      cmd           = '0;
        endcase
    end

endmodule

[src/pca_dp.sv]
// ----------------------------------------------------------------------------
// pca_dp
// Datapath: calibration registers, multiplier, radix-4 restoring divider,
// saturation, averaging ring with running sum, reciprocal mean, output
// register.
// ----------------------------------------------------------------------------
module pca_dp
    import pca_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic [SAMPLE_W-1:0]      adc_sample,
    input  cmd_t                     cmd,
    output status_t                  status,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic signed [MEAS_W-1:0] measured_pressure,
    output logic signed [MEAS_W-1:0] filtered_pressure,
    output logic [SAMPLE_W-1:0]      raw_echo,
    output logic                     span_error
);

    localparam int SLOT_W     = $clog2(WINDOW_LEN);
    localparam int SUM_W      = MEAS_W + $clog2(WINDOW_LEN);
    // reciprocal of WINDOW_LEN, rounded up; exact for every sum magnitude
    localparam int MEAN_SHIFT = SUM_W + $clog2(WINDOW_LEN);
    localparam int PROD_W     = SUM_W + MEAN_SHIFT;
    localparam logic [MEAN_SHIFT-1:0] MEAN_RECIP =
        MEAN_SHIFT'(((64'd1 << MEAN_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    // configuration
    logic [SAMPLE_W-1:0] zero_reg;
    logic [SAMPLE_W-1:0] span_reg;
    logic [PRESS_W-1:0]  press_reg;

    // item working registers
    logic [SAMPLE_W-1:0]      sample_reg;
    logic                     err_reg;
    logic                     neg_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [DIV_W-1:0]         quo_reg;
    logic signed [MEAS_W-1:0] meas_reg;

    // averaging state
    logic signed [MEAS_W-1:0] ring_reg [WINDOW_LEN];
    logic [SLOT_W-1:0]        slot_reg;
    logic signed [SUM_W-1:0]  sum_reg;

    logic out_valid_reg;

    // multiply stage
    logic signed [SAMPLE_W:0]       diff;
    logic signed [SAMPLE_W:0]       den_s;
    logic [SAMPLE_W:0]              scale;
    logic signed [2*SAMPLE_W+2:0]   prod;
    logic [2*SAMPLE_W+2:0]          prod_mag;
    logic [SAMPLE_W:0]              den_mag;

    assign diff     = $signed({1'b0, sample_reg}) - $signed({1'b0, zero_reg});
    assign den_s    = $signed({1'b0, span_reg}) - $signed({1'b0, zero_reg});
    assign scale    = (SAMPLE_W+1)'(press_reg) * (SAMPLE_W+1)'(TENTHS);
    assign prod     = diff * $signed({1'b0, scale});
    assign prod_mag = prod[2*SAMPLE_W+2] ? (~prod + 1'b1) : prod;
    assign den_mag  = den_s[SAMPLE_W] ? (~den_s + 1'b1) : den_s;

    // two restoring steps per cycle
    logic [REM_W-1:0] rem_step;
    logic [DIV_W-1:0] quo_step;
    logic [REM_W-1:0] rem_shift;

    always_comb
    begin
        rem_step = rem_reg;
        quo_step = quo_reg;
        for (int k = 0; k < DIV_RADIX; k++)
        begin
            rem_shift = {rem_step[DEN_W-1:0], quo_step[DIV_W-1]};
            quo_step  = {quo_step[DIV_W-2:0], 1'b0};
            if (rem_shift >= {1'b0, den_reg})
            begin
                rem_step    = rem_shift - {1'b0, den_reg};
                quo_step[0] = 1'b1;
            end
            else
            begin
                rem_step = rem_shift;
            end
        end
    end

    // saturate the signed calibration quotient
    logic signed [MEAS_W-1:0] meas_sat;

    always_comb
    begin
        if (err_reg)
        begin
            meas_sat = '0;
        end
        else if (!neg_reg)
        begin
            meas_sat = (quo_reg > DIV_W'(32767)) ? MEAS_MAX : MEAS_W'(quo_reg);
        end
        else
        begin
            meas_sat = (quo_reg > DIV_W'(32768)) ? MEAS_MIN : MEAS_W'(~quo_reg + 1'b1);
        end
    end

    // running sum of the ring
    logic signed [MEAS_W-1:0] ring_old;
    logic signed [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]         sum_mag;
    logic [PROD_W-1:0]        mean_prod;

    assign ring_old  = ring_reg[slot_reg];
    assign sum_next  = sum_reg - SUM_W'(ring_old) + SUM_W'(meas_reg);
    assign sum_mag   = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign mean_prod = PROD_W'(sum_mag) * PROD_W'(MEAN_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_reg  <= ZERO_OFFSET_RST;
            span_reg  <= SPAN_OFFSET_RST;
            press_reg <= SPAN_PRESSURE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ZERO_OFFSET:   zero_reg  <= cfg_data[SAMPLE_W-1:0];
                CFG_SPAN_OFFSET:   span_reg  <= cfg_data[SAMPLE_W-1:0];
                CFG_SPAN_PRESSURE: press_reg <= cfg_data[PRESS_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                ring_reg[i] <= '0;
            end
            slot_reg <= '0;
            sum_reg  <= '0;
        end
        else if (cmd.ring_upd)
        begin
            ring_reg[slot_reg] <= meas_reg;
            sum_reg            <= sum_next;
            if (slot_reg == SLOT_W'(WINDOW_LEN - 1))
            begin
                slot_reg <= '0;
            end
            else
            begin
                slot_reg <= slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg <= adc_sample;
            err_reg    <= (span_reg == zero_reg);
        end
        if (cmd.mul)
        begin
            neg_reg <= diff[SAMPLE_W] ^ den_s[SAMPLE_W];
            quo_reg <= prod_mag[DIV_W-1:0];
            rem_reg <= '0;
            den_reg <= den_mag[DEN_W-1:0];
        end
        else if (cmd.mean_load)
        begin
            // magnitude of the mean; the sign is put back at the output
            neg_reg <= sum_reg[SUM_W-1];
            quo_reg <= DIV_W'(mean_prod[PROD_W-1:MEAN_SHIFT]);
        end
        else if (cmd.div_step)
        begin
            quo_reg <= quo_step;
            rem_reg <= rem_step;
        end
        if (cmd.sat)
        begin
            meas_reg <= meas_sat;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            measured_pressure <= meas_reg;
            filtered_pressure <= neg_reg ? MEAS_W'(~quo_reg + 1'b1) : MEAS_W'(quo_reg);
            raw_echo          <= sample_reg;
            span_error        <= err_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.out_busy = out_valid_reg && !out_ready;

endmodule

[src/pressure_calibrate_and_average_core.sv]
// ----------------------------------------------------------------------------
// pressure_calibrate_and_average_core
// Two-point pressure calibration with a moving-average filter.
// ----------------------------------------------------------------------------
// Usage:
//   sample_in  carries one raw converter code per request; result_out returns
//   the saturated calibrated pressure (tenths), the mean of the last
//   WINDOW_LEN calibrated values, the raw code and the span error flag.
//   Calibration registers are written through cfg_we/cfg_index/cfg_data
//   while no request is in flight.
// Timing:
//   A request is taken only in the idle state, so the next request waits until
//   the previous result has been loaded into the output register. The
//   divider retires two quotient bits a cycle over the 22-bit calibration
//   product, and the mean is formed by a reciprocal multiply.
// Reset:
//   rst_n clears the ring, the running sum and the write slot, and loads the
//   calibration registers with their defaults.
// Stall:
//   A finished result waits in the output register; sample_in accepts the
//   next request meanwhile, and that request is held in its final cycle
//   until the output register frees.
// ----------------------------------------------------------------------------
module pressure_calibrate_and_average_core
    import pca_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    pca_in_if.sink                sample_in,
    pca_out_if.source             result_out
);

    cmd_t    cmd;
    status_t status;
    logic    in_ready;

    assign sample_in.ready = in_ready;

    pca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_in.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pca_dp #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .adc_sample        (sample_in.adc_sample),
        .cmd               (cmd),
        .status            (status),
        .out_ready         (result_out.ready),
        .out_valid         (result_out.valid),
        .measured_pressure (result_out.measured_pressure),
        .filtered_pressure (result_out.filtered_pressure),
        .raw_echo          (result_out.raw_echo),
        .span_error        (result_out.span_error)
    );

endmodule

[tb/pressure_calibrate_and_average_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pressure_calibrate_and_average_core_test
// Self-checking bench for the two-point calibration and moving-average core.
// Requests carry raw converter codes. A tracker class keeps its own
// calibration registers and ring of calibrated values. It works out every
// reading as the request is taken and checks each returned reading against the
// oldest one still waiting. A directed opening covers the extreme codes, equal
// offsets, a zero span pressure, saturation both ways and an ignored register
// index. Randomised phases with changing calibration and handshake stalls
// follow.
// ----------------------------------------------------------------------------
module pressure_calibrate_and_average_core_test;
    import pca_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam int SETTLE_CYCLES  = 32;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_ITEMS    = 148;
    localparam int CODE_MAX       = 1023;

    typedef struct packed {
        logic signed [MEAS_W-1:0] measured;
        logic signed [MEAS_W-1:0] filtered;
        logic [SAMPLE_W-1:0]      raw;
        logic                     span_err;
    } reading_t;

    class calib_tracker;
        logic [SAMPLE_W-1:0]      zero_off;
        logic [SAMPLE_W-1:0]      span_off;
        logic [PRESS_W-1:0]       span_press;
        logic signed [MEAS_W-1:0] ring [WINDOW_LEN_DEF];
        int                       slot;
        reading_t                 expected_readings [$];
        int                       mismatches;

        function new();
            zero_off   = ZERO_OFFSET_RST;
            span_off   = SPAN_OFFSET_RST;
            span_press = SPAN_PRESSURE_RST;
            foreach (ring[i])
                ring[i] = '0;
            slot       = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ZERO_OFFSET:   zero_off   = data[SAMPLE_W-1:0];
                CFG_SPAN_OFFSET:   span_off   = data[SAMPLE_W-1:0];
                CFG_SPAN_PRESSURE: span_press = data[PRESS_W-1:0];
                default: ;
            endcase
        endfunction

        function reading_t calibrate_and_average(logic [SAMPLE_W-1:0] code);
            reading_t r;
            int       code_i;
            int       zero_i;
            int       span_i;
            int       press_i;
            int       quot;
            int       sum;
            code_i  = int'(code);
            zero_i  = int'(zero_off);
            span_i  = int'(span_off);
            press_i = int'(span_press);
            r.raw   = code;
            if (zero_i == span_i)
            begin
                r.span_err = 1'b1;
                r.measured = '0;
            end
            else
            begin
                r.span_err = 1'b0;
                quot = ((code_i - zero_i) * (press_i * TENTHS)) / (span_i - zero_i);
                if (quot > 32767)
                    r.measured = MEAS_MAX;
                else if (quot < -32768)
                    r.measured = MEAS_MIN;
                else
                    r.measured = quot[MEAS_W-1:0];
            end
            ring[slot] = r.measured;
            slot = (slot + 1) % WINDOW_LEN_DEF;
            sum = 0;
            foreach (ring[i])
                sum += int'(ring[i]);
            sum = sum / WINDOW_LEN_DEF;
            r.filtered = sum[MEAS_W-1:0];
            return r;
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] code);
            expected_readings.push_back(calibrate_and_average(code));
        endfunction

        function void check_reading(reading_t got);
            reading_t want;
            if (expected_readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected reading: meas=%0d filt=%0d raw=%0d err=%0b",
                             got.measured, got.filtered, got.raw, got.span_err);
                return;
            end
            want = expected_readings.pop_front();
            if (got.measured !== want.measured || got.filtered !== want.filtered ||
                got.raw !== want.raw || got.span_err !== want.span_err)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch exp m=%0d f=%0d r=%0d e=%0b got m=%0d f=%0d r=%0d e=%0b",
                             want.measured, want.filtered, want.raw, want.span_err,
                             got.measured, got.filtered, got.raw, got.span_err);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pca_in_if  sample_if ();
    pca_out_if result_if ();

    calib_tracker sb;
    int           tx_idle_pct;
    int           rx_idle_pct;
    int           sent_count;

    pressure_calibrate_and_average_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (sample_if),
        .result_out (result_if)
    );

    always #1 clk = ~clk;

    // receiver stalls at the rate of the current idling phase
    initial
    begin
        result_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            result_if.ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
            sb.check_reading('{result_if.measured_pressure, result_if.filtered_pressure,
                               result_if.raw_echo, result_if.span_error});
    end

    // end the run after too long without any request or reading moving
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] code);
        if (sent_count < 450)
        begin
            tx_idle_pct = 19;
            rx_idle_pct = 60;
        end
        else if (sent_count < 900)
        begin
            tx_idle_pct = 60;
            rx_idle_pct = 19;
        end
        else
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        while ($urandom_range(99) < tx_idle_pct)
        begin
            sample_if.valid <= 1'b0;
            @(posedge clk);
        end
        sample_if.valid      <= 1'b1;
        sample_if.adc_sample <= code;
        @(posedge clk);
        while (!sample_if.ready)
            @(posedge clk);
        sb.note_sample(code);
        sent_count++;
    endtask

    // drop the request and hold until every reading is back and the core settles
    task automatic wait_until_idle();
        sample_if.valid <= 1'b0;
        while (sb.expected_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic program_regs(input int zero_code, input int span_code, input int press_data);
        wait_until_idle();
        write_cfg(CFG_ZERO_OFFSET, CFG_DATA_W'(zero_code));
        write_cfg(CFG_SPAN_OFFSET, CFG_DATA_W'(span_code));
        write_cfg(CFG_SPAN_PRESSURE, CFG_DATA_W'(press_data));
        cfg_we <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_code();
        int base;
        int jitter;
        int v;
        case ($urandom_range(9))
            0: return '0;
            1: return SAMPLE_W'(CODE_MAX);
            2, 3:
            begin
                base   = int'($urandom_range(1) ? sb.zero_off : sb.span_off);
                jitter = $urandom_range(8);
                v      = base + jitter - 4;
                if (v < 0)
                    v = 0;
                if (v > CODE_MAX)
                    v = CODE_MAX;
                return SAMPLE_W'(v);
            end
            default: return SAMPLE_W'($urandom_range(CODE_MAX));
        endcase
    endfunction

    initial
    begin
        int zc;
        int pd;
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_ZERO_OFFSET;
        cfg_data             = '0;
        sample_if.valid      = 1'b0;
        sample_if.adc_sample = '0;
        tx_idle_pct          = 0;
        rx_idle_pct          = 0;
        sent_count           = 0;
        sb                   = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset calibration, extreme codes
        send_sample('0);
        send_sample(SAMPLE_W'(CODE_MAX));
        send_sample(10'd512);
        send_sample(10'd341);
        // falling line with the largest in-range span pressure
        program_regs(CODE_MAX, 0, 100);
        send_sample('0);
        send_sample(SAMPLE_W'(CODE_MAX));
        send_sample(10'd1);
        // equal offsets: flag the error, feed zero into the ring
        program_regs(500, 500, 40);
        send_sample('0);
        send_sample(10'd500);
        send_sample(SAMPLE_W'(CODE_MAX));
        // steep line: saturate high and low
        program_regs(512, 513, 127);
        send_sample(SAMPLE_W'(CODE_MAX));
        send_sample('0);
        send_sample(10'd512);
        // zero span pressure gives zero without an error
        program_regs(0, CODE_MAX, 0);
        send_sample(SAMPLE_W'(CODE_MAX));
        send_sample(10'd700);
        // unused index is ignored; span pressure keeps only its low bits
        wait_until_idle();
        write_cfg(CFG_UNUSED_IDX, 10'h3FF);
        write_cfg(CFG_SPAN_PRESSURE, 10'h385);
        cfg_we <= 1'b0;
        send_sample(SAMPLE_W'(CODE_MAX));
        send_sample(10'd5);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            zc = $urandom_range(CODE_MAX);
            pd = int'({3'($urandom_range(7)), 7'($urandom_range(1, 100))});
            case (ph)
                0: program_regs(0, CODE_MAX, 40);
                1: program_regs(CODE_MAX, 0, 100);
                2: program_regs(zc, zc, pd);
                3: program_regs(0, 1, 127);
                4: program_regs(zc, $urandom_range(CODE_MAX), 0);
                5: program_regs(CODE_MAX, CODE_MAX - 1, 1);
                default: program_regs(zc, $urandom_range(CODE_MAX), pd);
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(pick_code());
        end

        wait_until_idle();
        if (sb.mismatches == 0 && sb.expected_readings.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
src/pca_pkg.sv
src/pca_in_if.sv
src/pca_out_if.sv
src/pca_ctrl.sv
src/pca_dp.sv
src/pressure_calibrate_and_average_core.sv
tb/pressure_calibrate_and_average_core_test.sv
